FILE: design/dwg_pkg.sv
// Shared constants, types and the sine table of the waveform table generator.
package dwg_pkg;

	localparam int TABLE_SAMPLES = 32;
	localparam int CLOCK_HZ = 64000000;
	localparam int FAST_FREQ_HZ = 100000;
	localparam int VREF_MIN_MV = 100;
	localparam int VREF_DEFAULT_MV = 3300;
	localparam int FULL_CODE = 4095;
	localparam int SCALE_SHIFT_HI = 20;  // 4095*256 = 2^20 - 2^8
	localparam int SCALE_SHIFT_LO = 8;
	localparam int RELOAD_MAX = 2097151;

	localparam int WAVE_W = 8;
	localparam int FREQ_W = 22;
	localparam int MV_W = 14;
	localparam int VREF_W = 13;
	localparam int SAMPLE_W = 12;
	localparam int POS_W = $clog2(TABLE_SAMPLES);
	localparam int RELOAD_W = 21;
	localparam int CODE_W = 26;
	localparam int SINE_W = 17;
	localparam int PROD_W = CODE_W + SINE_W;
	localparam int VAL_W = 30;
	localparam int SVAL_W = 36;

	localparam int DIVIDEND_W = 34;
	localparam int DIVISOR_W = 27;
	localparam int DIV_STEPS = DIVIDEND_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic signed [SVAL_W-1:0] CODE_MAX = 36'sd33554431;
	localparam logic signed [SVAL_W-1:0] CODE_MIN = -36'sd33554432;

	localparam logic [WAVE_W-1:0] WAVE_SINE = 8'd1;
	localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 8'd2;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE = 8'd3;

	typedef enum logic [1:0] {
		DIV_OFFSET = 2'd0,
		DIV_AMPL = 2'd1,
		DIV_RELOAD = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic load;
		logic div_start;
		div_sel_t div_sel;
		logic div_store;
		logic mul;
		logic emit;
		logic next;
	} dwg_cmd_t;

	typedef struct packed {
		logic div_done;
		logic rate_err;
		logic last;
	} dwg_stat_t;

	// Q1.15 sine, one full period over 32 entries.
	function automatic logic signed [SINE_W-1:0] sine_q15(input logic [4:0] k);
		logic signed [SINE_W-1:0] s;
		unique case (k)
			5'd0:  s = 17'sd0;
			5'd1:  s = 17'sd6393;
			5'd2:  s = 17'sd12540;
			5'd3:  s = 17'sd18205;
			5'd4:  s = 17'sd23170;
			5'd5:  s = 17'sd27246;
			5'd6:  s = 17'sd30274;
			5'd7:  s = 17'sd32138;
			5'd8:  s = 17'sd32767;
			5'd9:  s = 17'sd32138;
			5'd10: s = 17'sd30274;
			5'd11: s = 17'sd27246;
			5'd12: s = 17'sd23170;
			5'd13: s = 17'sd18205;
			5'd14: s = 17'sd12540;
			5'd15: s = 17'sd6393;
			5'd16: s = 17'sd0;
			5'd17: s = -17'sd6393;
			5'd18: s = -17'sd12540;
			5'd19: s = -17'sd18205;
			5'd20: s = -17'sd23170;
			5'd21: s = -17'sd27246;
			5'd22: s = -17'sd30274;
			5'd23: s = -17'sd32138;
			5'd24: s = -17'sd32767;
			5'd25: s = -17'sd32138;
			5'd26: s = -17'sd30274;
			5'd27: s = -17'sd27246;
			5'd28: s = -17'sd23170;
			5'd29: s = -17'sd18205;
			5'd30: s = -17'sd12540;
			5'd31: s = -17'sd6393;
			default: s = 17'sd0;
		endcase
		return s;
	endfunction

endpackage

FILE: design/dwg_if.sv
// Request and sample channel interfaces of the waveform table generator.
interface dwg_req_if import dwg_pkg::*; ();
	logic valid;
	logic ready;
	logic [WAVE_W-1:0] waveform;
	logic [FREQ_W-1:0] freq_hz;
	logic signed [MV_W-1:0] offset_mv;
	logic signed [MV_W-1:0] amplitude_mv;
	logic [VREF_W-1:0] vref_mv;

	modport source (output valid, waveform, freq_hz, offset_mv, amplitude_mv, vref_mv,
		input ready);
	modport sink (input valid, waveform, freq_hz, offset_mv, amplitude_mv, vref_mv,
		output ready);
endinterface

interface dwg_smp_if import dwg_pkg::*; ();
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] sample;
	logic [POS_W-1:0] sample_index;
	logic last;
	logic [RELOAD_W-1:0] timer_reload;
	logic rate_error;

	modport source (output valid, sample, sample_index, last, timer_reload, rate_error,
		input ready);
	modport sink (input valid, sample, sample_index, last, timer_reload, rate_error,
		output ready);
endinterface

FILE: design/dwg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module dwg_div import dwg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic done,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic rem_nonzero
);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] den_q;
	logic [DIVISOR_W:0] trial;
	logic fits;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= STEP_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so it fits the divisor width.
			rem_q <= fits ? DIVISOR_W'(trial - {1'b0, den_q}) : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign rem_nonzero = |rem_q;

endmodule

FILE: design/dwg_datapath.sv
// Scaling, reload and sample datapath of the waveform table generator.
module dwg_datapath import dwg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  dwg_cmd_t cmd,
	output dwg_stat_t stat,
	input  logic [WAVE_W-1:0] waveform,
	input  logic [FREQ_W-1:0] freq_hz,
	input  logic signed [MV_W-1:0] offset_mv,
	input  logic signed [MV_W-1:0] amplitude_mv,
	input  logic [VREF_W-1:0] vref_mv,
	output logic [SAMPLE_W-1:0] sample,
	output logic [POS_W-1:0] sample_index,
	output logic last,
	output logic [RELOAD_W-1:0] timer_reload,
	output logic rate_error
);

	logic [WAVE_W-1:0] wave_q;
	logic signed [MV_W-1:0] offs_q;
	logic signed [MV_W-1:0] ampl_q;
	logic [VREF_W-1:0] vref_q;
	logic [DIVISOR_W-1:0] rate_q;
	logic fast_q;
	logic err_q;
	logic [POS_W-1:0] pos_q;
	logic signed [CODE_W-1:0] center_q;
	logic signed [CODE_W-1:0] swing_q;
	logic [RELOAD_W-1:0] reload_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [SAMPLE_W-1:0] sample_q;

	logic in_fast;
	logic [DIVISOR_W-1:0] in_rate;
	logic mv_neg;
	logic [MV_W-1:0] mv_mag;
	logic [DIVIDEND_W-1:0] dividend;
	logic [DIVISOR_W-1:0] divisor;
	logic div_done;
	logic [DIVIDEND_W-1:0] div_quo;
	logic div_rnz;
	logic signed [SVAL_W-1:0] quo_signed;
	logic signed [SVAL_W-1:0] scaled;
	logic [CODE_W-1:0] scaled_sat;
	logic [DIVIDEND_W-1:0] reload_raw;

	logic first_half;
	logic pos_last;
	logic signed [6:0] tri_down;
	logic signed [SINE_W-1:0] mul_op;
	logic [4:0] sine_k;
	logic [3:0] shift_amt;
	logic signed [PROD_W-1:0] prod_shift;
	logic signed [VAL_W-1:0] part;
	logic signed [VAL_W-1:0] c30;
	logic signed [VAL_W-1:0] s30;
	logic signed [VAL_W-1:0] val;
	logic [SAMPLE_W-1:0] code;

	// Request capture: table length, sample rate and rate check.
	assign in_fast = freq_hz >= FREQ_W'(FAST_FREQ_HZ);
	assign in_rate = in_fast ? {1'b0, freq_hz, 4'b0} : {freq_hz, 5'b0};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wave_q <= waveform;
			offs_q <= offset_mv;
			ampl_q <= amplitude_mv;
			vref_q <= (vref_mv <= VREF_W'(VREF_MIN_MV)) ? VREF_W'(VREF_DEFAULT_MV) : vref_mv;
			rate_q <= in_rate;
			fast_q <= in_fast;
			err_q <= (freq_hz == '0) || (in_rate > DIVISOR_W'(CLOCK_HZ));
		end
	end

	// Divider operands: scaled magnitude over the reference, or clock over rate.
	assign mv_neg = (cmd.div_sel == DIV_AMPL) ? ampl_q[MV_W-1] : offs_q[MV_W-1];
	assign mv_mag = (cmd.div_sel == DIV_AMPL)
		? (ampl_q[MV_W-1] ? MV_W'(-ampl_q) : ampl_q)
		: (offs_q[MV_W-1] ? MV_W'(-offs_q) : offs_q);

	always_comb begin
		unique case (cmd.div_sel)
			DIV_OFFSET, DIV_AMPL: begin
				dividend = (DIVIDEND_W'(mv_mag) << SCALE_SHIFT_HI)
					- (DIVIDEND_W'(mv_mag) << SCALE_SHIFT_LO);
				divisor = DIVISOR_W'(vref_q);
			end
			DIV_RELOAD: begin
				dividend = DIVIDEND_W'(CLOCK_HZ);
				divisor = rate_q;
			end
			default: begin
				dividend = '0;
				divisor = DIVISOR_W'(1);
			end
		endcase
	end

	dwg_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(dividend),
		.divisor(divisor),
		.done(div_done),
		.quotient(div_quo),
		.rem_nonzero(div_rnz)
	);

	// Floor division of a negative value rounds the magnitude quotient up.
	assign quo_signed = $signed({2'b00, div_quo});
	assign scaled = mv_neg ? -(quo_signed + $signed({35'd0, div_rnz})) : quo_signed;
	assign scaled_sat = (scaled > CODE_MAX) ? CODE_MAX[CODE_W-1:0]
		: (scaled < CODE_MIN) ? CODE_MIN[CODE_W-1:0] : scaled[CODE_W-1:0];
	assign reload_raw = div_quo - DIVIDEND_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.load) begin
			pos_q <= '0;
		end else if (cmd.next) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			reload_q <= '0;
		end else if (cmd.div_store) begin
			unique case (cmd.div_sel)
				DIV_OFFSET: center_q <= $signed(scaled_sat);
				DIV_AMPL:   swing_q <= $signed(scaled_sat);
				DIV_RELOAD: reload_q <= (reload_raw > DIVIDEND_W'(RELOAD_MAX))
					? RELOAD_W'(RELOAD_MAX) : reload_raw[RELOAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample generation: one product per sample, then shift, offset and clamp.
	assign first_half = fast_q ? !pos_q[POS_W-2] : !pos_q[POS_W-1];
	assign pos_last = pos_q == (fast_q ? POS_W'(TABLE_SAMPLES/2 - 1) : POS_W'(TABLE_SAMPLES - 1));
	assign tri_down = $signed({1'b0, pos_q, 1'b0})
		- (fast_q ? 7'sd16 : 7'sd32);
	assign sine_k = fast_q ? {pos_q[3:0], 1'b0} : pos_q;

	always_comb begin
		case (wave_q)
			WAVE_SINE:     mul_op = sine_q15(sine_k);
			WAVE_TRIANGLE: mul_op = first_half ? $signed({{(SINE_W-POS_W){1'b0}}, pos_q})
				: SINE_W'(tri_down);
			default:       mul_op = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= swing_q * mul_op;
		end
	end

	always_comb begin
		if (wave_q == WAVE_SINE) begin
			shift_amt = 4'd15;
		end else if (first_half) begin
			shift_amt = fast_q ? 4'd2 : 4'd3;
		end else begin
			shift_amt = fast_q ? 4'd3 : 4'd4;
		end
	end

	assign prod_shift = prod_s1 >>> shift_amt;
	assign part = prod_shift[VAL_W-1:0];
	assign c30 = VAL_W'(center_q);
	assign s30 = VAL_W'(swing_q);

	always_comb begin
		case (wave_q)
			WAVE_SINE:     val = c30 + part;
			WAVE_TRIANGLE: val = first_half ? c30 - s30 + part : c30 + s30 - part;
			WAVE_SQUARE:   val = first_half ? c30 + s30 : c30 - s30;
			default:       val = c30;
		endcase
	end

	always_comb begin
		if (val[VAL_W-1]) begin
			code = '0;
		end else if (|val[VAL_W-1:SAMPLE_W+8]) begin
			code = SAMPLE_W'(FULL_CODE);
		end else begin
			code = val[SAMPLE_W+7:8];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sample_q <= code;
		end
	end

	assign sample = sample_q;
	assign sample_index = pos_q;
	assign last = pos_last;
	assign timer_reload = reload_q;
	assign rate_error = err_q;

	assign stat.div_done = div_done;
	assign stat.rate_err = err_q;
	assign stat.last = pos_last;

endmodule

FILE: design/dwg_ctrl.sv
// Sequencing state machine of the waveform table generator.
module dwg_ctrl import dwg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic smp_valid,
	input  logic smp_ready,
	output dwg_cmd_t cmd,
	input  dwg_stat_t stat
);

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_OFF_GO  = 10'b0000000010,
		S_OFF_RUN = 10'b0000000100,
		S_AMP_GO  = 10'b0000001000,
		S_AMP_RUN = 10'b0000010000,
		S_RLD_GO  = 10'b0000100000,
		S_RLD_RUN = 10'b0001000000,
		S_MUL     = 10'b0010000000,
		S_EMIT    = 10'b0100000000,
		S_WAIT    = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.div_sel = DIV_OFFSET;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_OFF_GO;
				end
			end
			S_OFF_GO: begin
				cmd.div_start = 1'b1;
				state_d = S_OFF_RUN;
			end
			S_OFF_RUN: begin
				if (stat.div_done) begin
					cmd.div_store = 1'b1;
					state_d = S_AMP_GO;
				end
			end
			S_AMP_GO: begin
				cmd.div_sel = DIV_AMPL;
				cmd.div_start = 1'b1;
				state_d = S_AMP_RUN;
			end
			S_AMP_RUN: begin
				cmd.div_sel = DIV_AMPL;
				if (stat.div_done) begin
					cmd.div_store = 1'b1;
					// A rejected rate keeps the reload at zero.
					state_d = stat.rate_err ? S_MUL : S_RLD_GO;
				end
			end
			S_RLD_GO: begin
				cmd.div_sel = DIV_RELOAD;
				cmd.div_start = 1'b1;
				state_d = S_RLD_RUN;
			end
			S_RLD_RUN: begin
				cmd.div_sel = DIV_RELOAD;
				if (stat.div_done) begin
					cmd.div_store = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (smp_ready) begin
					if (stat.last) begin
						state_d = S_IDLE;
					end else begin
						cmd.next = 1'b1;
						state_d = S_MUL;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign smp_valid = state_q == S_WAIT;

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !smp_valid)
		else $error("request taken while a sample is pending");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_valid && smp_ready && stat.last) |=> req_ready)
		else $error("block not ready after the final sample");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second request taken before the table ended");
`endif

endmodule

FILE: design/dac_waveform_table_generator_top.sv
// Top level of the lookup-table waveform generator for a 12-bit converter.
//
// A request on req carries shape, frequency, offset, amplitude and reference.
// The block answers with one table on smp: 16 samples for 100 kHz and above,
// 32 otherwise, each with its index, a last flag on the final sample, the
// 64 MHz timer reload and the rate error flag (reload 0 on error).
// One request is handled at a time; req.ready is high only while idle.
// A request is captured while idle, then three 34-step divisions run on a shared
// bit-serial divider (offset scale, amplitude scale, reload; the reload one
// is skipped on a rate error) before the first sample is valid. Each sample
// then passes through multiply, clamp and hand over, plus any stall, and
// the next request is taken only after the last sample is handed over.
// When the receiver stalls, the current sample is held unchanged on smp and
// no further work is done. Reset returns the block to idle and drops any
// request in progress.
module dac_waveform_table_generator_top import dwg_pkg::*; (
	input logic clk,
	input logic arst_n,
	dwg_req_if.sink req,
	dwg_smp_if.source smp
);

	dwg_cmd_t cmd;
	dwg_stat_t stat;

	dwg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.smp_valid(smp.valid),
		.smp_ready(smp.ready),
		.cmd(cmd),
		.stat(stat)
	);

	dwg_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.waveform(req.waveform),
		.freq_hz(req.freq_hz),
		.offset_mv(req.offset_mv),
		.amplitude_mv(req.amplitude_mv),
		.vref_mv(req.vref_mv),
		.sample(smp.sample),
		.sample_index(smp.sample_index),
		.last(smp.last),
		.timer_reload(smp.timer_reload),
		.rate_error(smp.rate_error)
	);

endmodule

FILE: dv/dac_waveform_table_generator_top_tb.sv
// Self-checking testbench of the waveform table generator: predicts each sample table and checks it.
module dac_waveform_table_generator_top_tb;
	import dwg_pkg::*;

	localparam int RANDOM_PER_PHASE = 42;
	localparam int LONG_STALL_CYCLES = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam logic [WAVE_W-1:0] WAVE_FLAT = 8'd0;
	localparam logic [WAVE_W-1:0] WAVE_OTHER_MAX = 8'hFF;

	typedef struct {
		logic [WAVE_W-1:0] waveform;
		logic [FREQ_W-1:0] freq_hz;
		logic signed [MV_W-1:0] offset_mv;
		logic signed [MV_W-1:0] amplitude_mv;
		logic [VREF_W-1:0] vref_mv;
	} wave_request_t;

	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic [POS_W-1:0] sample_index;
		logic last;
		logic [RELOAD_W-1:0] timer_reload;
		logic rate_error;
	} table_sample_t;

	class table_scoreboard;
		table_sample_t expected_q[$];
		int sine_tab[32];
		int errors;
		int requests;
		int samples;
		int error_tables;
		int shape_seen[4];

		function new();
			sine_tab = '{0, 6393, 12540, 18205, 23170, 27246, 30274, 32138,
				32767, 32138, 30274, 27246, 23170, 18205, 12540, 6393,
				0, -6393, -12540, -18205, -23170, -27246, -30274, -32138,
				-32767, -32138, -30274, -27246, -23170, -18205, -12540, -6393};
		endfunction

		// Division rounding toward minus infinity; the divisor is always positive here.
		function longint div_floor(longint a, longint d);
			longint q;
			q = a / d;
			if ((a % d) != 0 && a < 0)
				q = q - 1;
			return q;
		endfunction

		function longint mv_to_code(longint mv, longint vref);
			longint c;
			c = div_floor(mv * FULL_CODE * 256, vref);
			if (c > longint'(CODE_MAX))
				c = longint'(CODE_MAX);
			if (c < longint'(CODE_MIN))
				c = longint'(CODE_MIN);
			return c;
		endfunction

		function logic [SAMPLE_W-1:0] clamp_code(longint q8);
			if (q8 < 0)
				return '0;
			if (q8 / 256 > FULL_CODE)
				return SAMPLE_W'(FULL_CODE);
			return SAMPLE_W'(q8 / 256);
		endfunction

		function void note_request(wave_request_t r);
			longint vref;
			longint center;
			longint swing;
			longint v;
			longint n;
			longint rate;
			longint q;
			logic [RELOAD_W-1:0] reload;
			logic err;
			table_sample_t s;
			int k;
			vref = longint'(r.vref_mv);
			if (vref <= VREF_MIN_MV)
				vref = VREF_DEFAULT_MV;
			center = mv_to_code(longint'(r.offset_mv), vref);
			swing = mv_to_code(longint'(r.amplitude_mv), vref);
			n = (r.freq_hz >= FAST_FREQ_HZ) ? TABLE_SAMPLES / 2 : TABLE_SAMPLES;
			rate = longint'(r.freq_hz) * n;
			err = 1'b0;
			reload = '0;
			if (r.freq_hz == 0 || rate > CLOCK_HZ) begin
				err = 1'b1;
			end else begin
				q = CLOCK_HZ / rate - 1;
				if (q > RELOAD_MAX)
					q = RELOAD_MAX;
				reload = RELOAD_W'(q);
			end
			for (longint i = 0; i < n; i++) begin
				v = center;
				case (r.waveform)
					WAVE_SINE: begin
						k = int'((i * 32 / n) % 32);
						v = center + div_floor(swing * sine_tab[k], 32768);
					end
					WAVE_TRIANGLE: begin
						if (i < n / 2)
							v = center - swing + div_floor(4 * swing * i, n);
						else
							v = center + swing - div_floor(2 * swing * (2 * i - n), n);
					end
					WAVE_SQUARE: begin
						v = (i < n / 2) ? center + swing : center - swing;
					end
					default: begin
					end
				endcase
				s.sample = clamp_code(v);
				s.sample_index = POS_W'(i);
				s.last = (i == n - 1);
				s.timer_reload = reload;
				s.rate_error = err;
				expected_q.push_back(s);
			end
			requests++;
			if (err)
				error_tables++;
			if (r.waveform == WAVE_SINE || r.waveform == WAVE_TRIANGLE || r.waveform == WAVE_SQUARE)
				shape_seen[r.waveform]++;
			else
				shape_seen[0]++;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_sample(table_sample_t got);
			table_sample_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected sample %0d at index %0d, no table pending",
					$time, got.sample, got.sample_index);
				return;
			end
			want = expected_q.pop_front();
			samples++;
			compare_field("sample", want.sample, got.sample);
			compare_field("sample_index", want.sample_index, got.sample_index);
			compare_field("last", want.last, got.last);
			compare_field("timer_reload", want.timer_reload, got.timer_reload);
			compare_field("rate_error", want.rate_error, got.rate_error);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic long_stall_req = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_left = 0;
	int unsigned cycle_count = 0;
	table_scoreboard board;

	dwg_req_if req_ch();
	dwg_smp_if smp_ch();

	dac_waveform_table_generator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.smp(smp_ch)
	);

	always #1 clk = ~clk;

	// The receiver owns the long stall count; the stimulus only asks for one.
	always @(posedge clk) begin
		if (long_stall_req)
			stall_left = LONG_STALL_CYCLES;
		if (stall_left > 0) begin
			stall_left--;
			smp_ch.ready <= 1'b0;
		end else begin
			smp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		wave_request_t seen;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			seen.waveform = req_ch.waveform;
			seen.freq_hz = req_ch.freq_hz;
			seen.offset_mv = req_ch.offset_mv;
			seen.amplitude_mv = req_ch.amplitude_mv;
			seen.vref_mv = req_ch.vref_mv;
			board.note_request(seen);
		end
	end

	always @(posedge clk) begin
		table_sample_t got;
		if (arst_n && smp_ch.valid && smp_ch.ready) begin
			got.sample = smp_ch.sample;
			got.sample_index = smp_ch.sample_index;
			got.last = smp_ch.last;
			got.timer_reload = smp_ch.timer_reload;
			got.rate_error = smp_ch.rate_error;
			board.check_sample(got);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d samples outstanding",
				cycle_count, board.pending());
			$display("dac_waveform_table_generator_top_tb: FAIL");
			$finish;
		end
	end

	function automatic wave_request_t make_request(logic [WAVE_W-1:0] w, int f, int o, int a,
		int v);
		wave_request_t r;
		r.waveform = w;
		r.freq_hz = FREQ_W'(f);
		r.offset_mv = MV_W'(o);
		r.amplitude_mv = MV_W'(a);
		r.vref_mv = VREF_W'(v);
		return r;
	endfunction

	// Mostly well-formed requests, with a share of raw bit patterns and corner values.
	function automatic wave_request_t random_request();
		wave_request_t r;
		int pick;
		r.waveform = ($urandom_range(9) == 0) ? WAVE_W'($urandom) : WAVE_W'($urandom_range(3, 1));
		pick = $urandom_range(19);
		if (pick == 0)
			r.freq_hz = '0;
		else if (pick <= 2)
			r.freq_hz = FREQ_W'($urandom);
		else if (pick <= 10)
			r.freq_hz = FREQ_W'($urandom_range(FAST_FREQ_HZ - 1, 1));
		else
			r.freq_hz = FREQ_W'($urandom_range(CLOCK_HZ / (TABLE_SAMPLES / 2), FAST_FREQ_HZ));
		if ($urandom_range(9) == 0)
			r.offset_mv = MV_W'($urandom);
		else
			r.offset_mv = MV_W'(int'($urandom_range(10000)) - 5000);
		if ($urandom_range(9) == 0)
			r.amplitude_mv = MV_W'($urandom);
		else
			r.amplitude_mv = MV_W'(int'($urandom_range(10000)) - 5000);
		pick = $urandom_range(9);
		if (pick == 0)
			r.vref_mv = VREF_W'($urandom_range(VREF_MIN_MV));
		else if (pick == 1)
			r.vref_mv = VREF_W'($urandom);
		else
			r.vref_mv = VREF_W'($urandom_range(5000, VREF_MIN_MV + 1));
		return r;
	endfunction

	task automatic send_request(input wave_request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.waveform <= r.waveform;
		req_ch.freq_hz <= r.freq_hz;
		req_ch.offset_mv <= r.offset_mv;
		req_ch.amplitude_mv <= r.amplitude_mv;
		req_ch.vref_mv <= r.vref_mv;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_directed();
		send_request(make_request(WAVE_SINE, 1000, 1650, 1000, 3300));
		send_request(make_request(WAVE_TRIANGLE, 1000, 1650, 1000, 3300));
		send_request(make_request(WAVE_SQUARE, 1000, 1650, 1000, 3300));
		send_request(make_request(WAVE_FLAT, 1000, 1650, 1000, 3300));
		send_request(make_request(WAVE_SINE, 0, 1650, 1000, 3300));
		send_request(make_request(WAVE_TRIANGLE, FAST_FREQ_HZ - 1, 1650, 1200, 3300));
		send_request(make_request(WAVE_SINE, FAST_FREQ_HZ, 1650, 1200, 3300));
		// Exactly the clock rate with 16 samples is still legal and gives reload 0.
		send_request(make_request(WAVE_SQUARE, 4000000, 1000, 500, 3300));
		send_request(make_request(WAVE_TRIANGLE, 4000001, 1000, 500, 3300));
		send_request(make_request(WAVE_SINE, 4194303, 1000, 500, 3300));
		send_request(make_request(WAVE_TRIANGLE, 1, 2000, 700, 3300));
		send_request(make_request(WAVE_SINE, 5000, 1650, 800, 0));
		send_request(make_request(WAVE_TRIANGLE, 5000, 1650, 800, VREF_MIN_MV));
		send_request(make_request(WAVE_SINE, 5000, 8191, -8192, VREF_MIN_MV + 1));
		send_request(make_request(WAVE_TRIANGLE, 20000, -8192, 8191, 8191));
		send_request(make_request(WAVE_SQUARE, 20000, 5000, 5000, 3300));
		send_request(make_request(WAVE_SINE, 20000, -5000, 3000, 3300));
		send_request(make_request(WAVE_TRIANGLE, FAST_FREQ_HZ, 1650, -1234, 3300));
		send_request(make_request(WAVE_TRIANGLE, 300, 1, 1, 3));
		send_request(make_request(WAVE_OTHER_MAX, 2000000, 2500, -7, 5000));
	endtask

	initial begin
		board = new();
		req_ch.valid = 1'b0;
		req_ch.waveform = '0;
		req_ch.freq_hz = '0;
		req_ch.offset_mv = '0;
		req_ch.amplitude_mv = '0;
		req_ch.vref_mv = '0;
		smp_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_drained();

		send_idle_pct = 19;
		recv_idle_pct = 51;
		repeat (RANDOM_PER_PHASE) send_request(random_request());
		wait_drained();

		send_idle_pct = 51;
		recv_idle_pct = 19;
		repeat (RANDOM_PER_PHASE) send_request(random_request());
		wait_drained();

		// Hold the sample side off while requests keep coming, so the input stalls.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_stall_req <= 1'b1;
		@(posedge clk);
		long_stall_req <= 1'b0;
		repeat (4) send_request(random_request());
		wait_drained();

		repeat (RANDOM_PER_PHASE) send_request(random_request());
		wait_drained();

		$display("Covered %0d requests: %0d sine, %0d triangle, %0d square, %0d flat;",
			board.requests, board.shape_seen[WAVE_SINE], board.shape_seen[WAVE_TRIANGLE],
			board.shape_seen[WAVE_SQUARE], board.shape_seen[0]);
		$display("%0d with a rate error; checked %0d samples under varied back-pressure, %0d mismatches.",
			board.error_tables, board.samples, board.errors);
		if (board.errors == 0 && board.pending() == 0)
			$display("dac_waveform_table_generator_top_tb: PASS");
		else
			$display("dac_waveform_table_generator_top_tb: FAIL");
		$finish;
	end

endmodule
